### design/tmw_pkg.sv
// ----------------------------------------------------------------------------
// Trimmed mean window package
// Shared constants, cell types and controller states.
// ----------------------------------------------------------------------------
package tmw_pkg;

  localparam int unsigned SAMPLE_W       = 18;
  localparam int unsigned WINDOW_DEFAULT = 20;
  localparam int unsigned TRIM_DEFAULT   = 2;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic    valid;
    sample_t value;
  } cell_t;

  typedef struct packed {
    logic    insert;
    logic    drain;
    sample_t x;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_DRAIN,
    ST_DIV,
    ST_HOLD
  } tmw_state_e;

endpackage

### design/tmw_sample_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one input sample per transaction.
// ----------------------------------------------------------------------------
interface tmw_sample_if;
  logic                         valid;
  logic                         ready;
  logic [tmw_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

### design/tmw_mean_if.sv
// ----------------------------------------------------------------------------
// Mean channel
// Valid/ready channel that carries one trimmed mean per transaction.
// ----------------------------------------------------------------------------
interface tmw_mean_if;
  logic                         valid;
  logic                         ready;
  logic [tmw_pkg::SAMPLE_W-1:0] mean;

  modport source (output valid, output mean, input ready);
  modport sink (input valid, input mean, output ready);
endinterface

### design/tmw_cell.sv
// ----------------------------------------------------------------------------
// Sorting cell
// One slot of the insertion chain. Cells stay in ascending order; an insert
// shifts the larger values one place up, and a drain shifts everything down.
// ----------------------------------------------------------------------------
module tmw_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tmw_pkg::cell_ctrl_t ctrl_i,
  input  tmw_pkg::cell_t      prev_i,
  input  logic                prev_gt_i,
  input  tmw_pkg::cell_t      next_i,
  output tmw_pkg::cell_t      cell_o,
  output logic                gt_o
);
  import tmw_pkg::*;

  logic    valid_q, valid_d;
  sample_t value_q, value_d;

  assign gt_o   = !valid_q || (value_q > ctrl_i.x);
  assign cell_o = '{valid: valid_q, value: value_q};

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctrl_i.drain) begin
      valid_d = next_i.valid;
      value_d = next_i.value;
    end else if (ctrl_i.insert && gt_o) begin
      if (prev_gt_i) begin
        valid_d = prev_i.valid;
        value_d = prev_i.value;
      end else begin
        valid_d = 1'b1;
        value_d = ctrl_i.x;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

### design/tmw_div.sv
// ----------------------------------------------------------------------------
// Constant divider
// Divides the window sum by the kept count with a reciprocal multiply. The
// dividend is registered on start and the quotient in the cycle after.
// ----------------------------------------------------------------------------
module tmw_div #(
  parameter int unsigned DIVIDEND_W = 23,
  parameter int unsigned DIVISOR    = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [DIVIDEND_W-1:0]        dividend_i,
  output logic                         done_o,
  output logic [tmw_pkg::SAMPLE_W-1:0] quot_o
);
  import tmw_pkg::*;

  localparam int unsigned SHIFT      = DIVIDEND_W + $clog2(DIVISOR);
  localparam int unsigned RECIP_W    = DIVIDEND_W + 1;
  localparam int unsigned PROD_W     = DIVIDEND_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  logic [DIVIDEND_W-1:0] acc_q;
  sample_t               quot_q;
  logic                  busy_q;
  logic                  done_q;
  logic [PROD_W-1:0]     product;

  // The reciprocal is rounded up, which gives the exact floor for every
  // dividend of DIVIDEND_W bits.
  assign product = {{RECIP_W{1'b0}}, acc_q} * {{DIVIDEND_W{1'b0}}, RECIP};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start_i;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
    end
    if (busy_q) begin
      quot_q <= product[SHIFT +: SAMPLE_W];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### design/trimmed_mean_window.sv
// ----------------------------------------------------------------------------
// Trimmed mean window
// Collects WINDOW samples, drops the TRIM smallest and TRIM largest, and
// returns the floor of the mean of the rest.
// ----------------------------------------------------------------------------
// Samples enter a chain of WINDOW sorting cells at one transaction per cycle
// while the block is filling, each placed in ascending order as it arrives.
// When the window is full the chain shifts its contents out through an
// accumulator one cell at a time, summing only the kept ranks, and a
// reciprocal multiply then forms the mean, after which the result is loaded
// into the output register once that register is free. No samples are taken
// between the last sample of a window and that load. If the previous mean is
// still waiting in the output register at that point, the block holds there
// and takes no samples until that mean is taken. With WINDOW no larger than
// twice TRIM the mean is zero.
// ----------------------------------------------------------------------------
module trimmed_mean_window #(
  parameter int unsigned WINDOW = tmw_pkg::WINDOW_DEFAULT,
  parameter int unsigned TRIM   = tmw_pkg::TRIM_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tmw_sample_if.sink  sample_i,
  tmw_mean_if.source  mean_o
);
  import tmw_pkg::*;

  localparam int unsigned KEEP    = (WINDOW > 2 * TRIM) ? (WINDOW - 2 * TRIM) : 0;
  localparam int unsigned DIVISOR = (KEEP == 0) ? 1 : KEEP;
  localparam int unsigned SUM_W   = SAMPLE_W + $clog2(WINDOW + 1);
  localparam int unsigned CNT_W   = $clog2(WINDOW + 1);

  tmw_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             out_valid_q, out_valid_d;
  sample_t          mean_q, mean_d;

  logic             in_ready;
  logic             accept;
  logic             drain;
  logic             last_cnt;
  logic             div_start;
  logic             load;
  logic             div_done;
  sample_t          quot;
  logic             keep_rank;
  logic [SUM_W-1:0] sum_add;

  cell_ctrl_t       ctrl;
  cell_t            cells [WINDOW];
  logic             gts   [WINDOW];

  assign accept   = sample_i.valid && in_ready;
  assign last_cnt = (cnt_q == CNT_W'(WINDOW - 1));
  assign ctrl     = '{insert: accept, drain: drain, x: sample_i.sample};

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    cell_t prev_cell;
    cell_t next_cell;
    logic  prev_gt;

    if (i == 0) begin : g_first
      assign prev_cell = '0;
      assign prev_gt   = 1'b0;
    end else begin : g_inner
      assign prev_cell = cells[i-1];
      assign prev_gt   = gts[i-1];
    end

    if (i == WINDOW - 1) begin : g_last
      assign next_cell = '0;
    end else begin : g_body
      assign next_cell = cells[i+1];
    end

    tmw_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .prev_i    (prev_cell),
      .prev_gt_i (prev_gt),
      .next_i    (next_cell),
      .cell_o    (cells[i]),
      .gt_o      (gts[i])
    );
  end

  assign keep_rank = (cnt_q >= CNT_W'(TRIM)) && (cnt_q < CNT_W'(TRIM + KEEP));

  always_comb begin
    sum_add = sum_q;
    if (drain && keep_rank) begin
      sum_add = sum_q + SUM_W'(cells[0].value);
    end
    if (state_q == ST_FILL) begin
      sum_d = '0;
    end else begin
      sum_d = sum_add;
    end
  end

  tmw_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR    (DIVISOR)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_add),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_FILL: begin
        if (accept && last_cnt) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (last_cnt) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_q || mean_o.ready) begin
          state_d = ST_FILL;
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    drain     = 1'b0;
    div_start = 1'b0;
    load      = 1'b0;
    cnt_d     = cnt_q;
    unique case (state_q)
      ST_FILL: begin
        in_ready = 1'b1;
        if (accept) begin
          cnt_d = last_cnt ? '0 : cnt_q + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        drain     = 1'b1;
        div_start = last_cnt;
        cnt_d     = last_cnt ? '0 : cnt_q + CNT_W'(1);
      end
      ST_DIV: begin
        cnt_d = '0;
      end
      ST_HOLD: begin
        load = !out_valid_q || mean_o.ready;
      end
      default: cnt_d = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    mean_d      = mean_q;
    if (load) begin
      out_valid_d = 1'b1;
      mean_d      = quot;
    end else if (mean_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    mean_q <= mean_d;
  end

  assign sample_i.ready = in_ready;
  assign mean_o.valid   = out_valid_q;
  assign mean_o.mean    = mean_q;

endmodule

### sim/tb_trimmed_mean_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trimmed mean window testbench
// Feeds windows of echo-width samples into the block and compares each
// trimmed mean it returns against a mean computed here from the same
// samples. The run starts with one window of edge values, then random
// windows shaped like real echo data. The sender and receiver pacing changes
// from phase to phase, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_trimmed_mean_window;
  import tmw_pkg::*;

  localparam int unsigned WINDOW        = WINDOW_DEFAULT;
  localparam int unsigned TRIM          = TRIM_DEFAULT;
  localparam int unsigned SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
  localparam int unsigned PHASE_WINDOWS = 25;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned DRAIN_CYCLES  = 100;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  typedef enum int {
    SHAPE_UNIFORM,
    SHAPE_STEADY,
    SHAPE_TIMEOUTS,
    SHAPE_HIGH,
    SHAPE_FLAT
  } window_shape_e;

  localparam sample_t EDGE_WINDOW [WINDOW_DEFAULT] = '{
    18'd0, 18'd262143, 18'd0, 18'd262143, 18'd1, 18'd262142, 18'd131072,
    18'd131072, 18'd131071, 18'd131071, 18'd65535, 18'd196608, 18'd1,
    18'd262142, 18'd5, 18'd5, 18'd5, 18'd100000, 18'd262143, 18'd0
  };

  class mean_scoreboard;
    sample_t     window_q[$];
    sample_t     expected_means[$];
    int unsigned n_samples;
    int unsigned n_means;
    int unsigned n_errors;

    function void note_sample(sample_t s);
      sample_t     ordered[$];
      logic [31:0] kept_sum;
      sample_t     mean;
      n_samples++;
      window_q.push_back(s);
      if (window_q.size() == WINDOW) begin
        ordered = window_q;
        ordered.sort();
        kept_sum = '0;
        mean = '0;
        if (WINDOW > 2 * TRIM) begin
          for (int unsigned i = TRIM; i < WINDOW - TRIM; i++) begin
            kept_sum += ordered[i];
          end
          mean = sample_t'(kept_sum / (WINDOW - 2 * TRIM));
        end
        expected_means.push_back(mean);
        window_q.delete();
      end
    endfunction

    function void check_mean(sample_t got);
      sample_t want;
      n_means++;
      if (expected_means.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected mean, expected none, actual %0d", $time, got);
      end else begin
        want = expected_means.pop_front();
        if (got !== want) begin
          n_errors++;
          $display("%0t: mean mismatch, expected %0d, actual %0d", $time, want, got);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_means.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  bit          stress_hold;
  int unsigned cycle_count;

  mean_scoreboard sb;

  tmw_sample_if sample_if ();
  tmw_mean_if   mean_if ();

  trimmed_mean_window #(
    .WINDOW(WINDOW),
    .TRIM  (TRIM)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_if),
    .mean_o  (mean_if)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Run stopped after %0d cycles with %0d means outstanding.",
                 cycle_count, sb.pending());
        $display("tb_trimmed_mean_window: FAIL");
        $finish;
      end
    end
  end

  // The receiver paces itself and, once asked, holds off for a long stretch.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    mean_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (stress_hold && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        mean_if.ready <= 1'b0;
      end else begin
        mean_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && mean_if.valid && mean_if.ready) begin
      sb.check_mean(mean_if.mean);
    end
  end

  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < sender_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid  <= 1'b1;
    sample_if.sample <= s;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    sb.note_sample(s);
  endtask

  task automatic send_window();
    window_shape_e shape;
    int unsigned   base;
    sample_t       value;
    shape = window_shape_e'($urandom_range(0, 4));
    base = $urandom_range(150, 25000);
    if (shape == SHAPE_FLAT) begin
      case ($urandom_range(0, 2))
        0: base = 0;
        1: base = SAMPLE_MAX;
        default: base = $urandom_range(0, SAMPLE_MAX);
      endcase
    end
    for (int unsigned i = 0; i < WINDOW; i++) begin
      case (shape)
        SHAPE_UNIFORM: value = sample_t'($urandom_range(0, SAMPLE_MAX));
        SHAPE_STEADY: value = sample_t'(base + $urandom_range(0, 64) - 32);
        SHAPE_TIMEOUTS: begin
          if ($urandom_range(0, 2) == 0) begin
            value = '0;
          end else begin
            value = sample_t'(base + $urandom_range(0, 64) - 32);
          end
        end
        SHAPE_HIGH: begin
          if ($urandom_range(0, 3) == 0) begin
            value = sample_t'(SAMPLE_MAX);
          end else begin
            value = sample_t'(SAMPLE_MAX - $urandom_range(0, 15));
          end
        end
        default: value = sample_t'(base);
      endcase
      send_sample(value);
    end
  endtask

  initial begin
    sb = new();
    rst_ni           <= 1'b0;
    sample_if.valid  <= 1'b0;
    sample_if.sample <= '0;
    sender_idle_pct   = 21;
    receiver_idle_pct = 61;
    stress_hold       = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Timeouts, full-scale echoes and ties, with one of each extreme kept.
    foreach (EDGE_WINDOW[i]) begin
      send_sample(EDGE_WINDOW[i]);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct   = 21;
          receiver_idle_pct = 61;
        end
        1: begin
          sender_idle_pct   = 61;
          receiver_idle_pct = 21;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
          stress_hold       = 1'b1;
        end
      endcase
      repeat (PHASE_WINDOWS) send_window();
    end
    sample_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d means from %0d samples over three pacing phases,",
             sb.n_means, sb.n_samples);
    $display("including a %0d-cycle output hold-off; %0d mismatches.",
             HOLD_CYCLES, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("tb_trimmed_mean_window: PASS");
    end else begin
      $display("tb_trimmed_mean_window: FAIL");
    end
    $finish;
  end

endmodule
